/* hw/rtl/euclidean_mst_kth_largest_edge_defines.svh */
// Assertion macros for the MST k-th largest edge block
`ifndef EUCLIDEAN_MST_KTH_LARGEST_EDGE_DEFINES_SVH
`define EUCLIDEAN_MST_KTH_LARGEST_EDGE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define EMST_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define EMST_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hw/rtl/emst_pkg.sv */
// Shared types and constants for the MST k-th largest edge block
package emst_pkg;
    localparam int unsigned COORD_BITS = 16;
    localparam int unsigned SQ_W   = 33;
    localparam int unsigned DIST_W = 34;
    localparam int unsigned FIX_W  = 25;
    localparam int unsigned CNT_W  = 10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_COVER = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_SCAN,
        S_PICK,
        S_RANK,
        S_RANKW,
        S_SQRT,
        S_DONE
    } t_state;
endpackage

/* hw/rtl/euclidean_mst_kth_largest_edge.sv */
// Points load while start is high and busy is low. After the last point the block
// runs Prim over the N points (one point read per cycle per pass), ranks the tree
// edges and takes the root, or goes straight to the strobe when the set has too
// few points or k is at least N. One data set at a time; busy is high from the cycle
// after the last point and is low again in the strobe cycle; the one-cycle strobe
// cannot be stalled. Synchronous active-low reset clears control state, sets k to 1.
module euclidean_mst_kth_largest_edge #(
    parameter int unsigned MAX_POINTS    = 512,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [emst_pkg::CNT_W-1:0]            i_cfg_wdata,
    input  logic signed [emst_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [emst_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                                  i_last_point,
    output logic                                  o_strobe,
    output logic [emst_pkg::SQ_W-1:0]             o_squared_distance,
    output logic [emst_pkg::FIX_W-1:0]            o_distance_fixed,
    output logic [1:0]                            o_status
);
    import emst_pkg::*;
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned NW = $clog2(MAX_POINTS + 1);

    // memories
    logic signed [COORD_BITS-1:0] r_mx [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_my [MAX_POINTS];
    logic [DIST_W-1:0]            r_best [MAX_POINTS];
    logic                         r_intree [MAX_POINTS];

    t_state r_state, n_state;
    logic [NW-1:0]     r_cnt;
    logic [CNT_W-1:0]  r_k;
    logic [AW-1:0]     r_i;
    logic [NW-1:0]     r_step;
    logic [AW-1:0]     r_pick;
    logic [DIST_W-1:0] r_pick_d;
    logic              r_pick_v;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [SQ_W-1:0]   r_sq;
    logic [1:0]        r_stat;
    logic              r_ph;
    logic [AW-1:0]     r_ri;
    logic              r_rv;
    logic signed [COORD_BITS-1:0] r_rx, r_ry;
    logic [DIST_W-1:0] r_rb;
    logic              r_rt;
    logic [COORD_BITS:0] r_ax, r_ay;
    logic [2*COORD_BITS+1:0] r_d;
    logic              r_d_v, r_a_v;
    logic [AW-1:0]     r_ai, r_di;
    logic [DIST_W-1:0] r_ab, r_db;
    logic              r_at, r_dt;
    logic [NW-1:0]     r_n;
    logic              r_sq_go;

    logic [CNT_W-1:0] k_eff;
    assign k_eff = (r_k == '0) ? CNT_W'(1) : r_k;

    logic [AW-1:0] rank_idx;
    assign rank_idx = AW'(k_eff - CNT_W'(1));

    logic [1:0] init_stat;
    always_comb begin
        if (r_n < NW'(2))             init_stat = ST_FEW;
        else if (NW'(k_eff) >= r_n)   init_stat = ST_COVER;
        else                          init_stat = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    logic scan_end, sqrt_done;
    logic [FIX_W-1:0] root;
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (start && i_last_point) n_state = S_INIT;
            S_INIT:  n_state = (init_stat != ST_OK) ? S_DONE : S_SCAN;
            S_SCAN:  if (scan_end) n_state = S_PICK;
            S_PICK:  n_state = (r_step + NW'(2) >= r_n) ? S_RANK : S_SCAN;
            S_RANK:  n_state = S_RANKW;
            S_RANKW: n_state = S_SQRT;
            S_SQRT:  if (sqrt_done) n_state = S_DONE;
            S_DONE:  n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end
    assign busy = (r_state != S_LOAD);

    // distance pipeline: read -> abs diff -> square sum -> compare
    logic [DIST_W-1:0] cand;
    logic              upd;
    assign cand = DIST_W'(r_d);
    assign scan_end = (r_ph == 1'b0) && !r_rv && !r_a_v && !r_d_v;
    assign upd = r_d_v && !r_dt && (cand < r_db);

    logic [DIST_W-1:0] nb;
    always_comb begin
        nb = upd ? cand : r_db;
    end

    // chain of ranking cells fed by the tree edges
    logic              ins;
    logic [DIST_W-1:0] key;
    logic [MAX_POINTS-1:0] c_gt, c_vld;
    logic [DIST_W-1:0] c_val [MAX_POINTS];
    logic              clr;
    assign clr = (r_state == S_INIT);
    assign ins = (r_state == S_PICK) && r_pick_v;
    assign key = r_pick_d;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++) begin : g_cell
            emst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_clr     (clr),
                .i_ins     (ins),
                .i_key     (key),
                .i_prev_gt ((g == 0) ? 1'b1 : c_gt[(g == 0) ? 0 : g-1]),
                .i_prev_val(c_val[(g == 0) ? 0 : g-1]),
                .i_prev_vld((g == 0) ? 1'b0 : c_vld[(g == 0) ? 0 : g-1]),
                .o_gt      (c_gt[g]),
                .o_val     (c_val[g]),
                .o_vld     (c_vld[g])
            );
        end
    endgenerate

    emst_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_sq_go),
        .i_sq   (r_sq),
        .o_done (sqrt_done),
        .o_root (root)
    );

    logic [FIX_W-1:0] r_root;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_k      <= CNT_W'(1);
            r_ph     <= 1'b0;
            r_rv     <= 1'b0;
            r_a_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_sq_go  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_sq_go  <= 1'b0;
            if (i_cfg_we) r_k <= i_cfg_wdata;
            // pipeline stages: memory read (valid cleared here), abs diff, square sum
            r_rv <= 1'b0;
            r_a_v <= r_rv;
            r_d_v <= r_a_v;
            r_ax <= (r_rx >= r_px) ? (COORD_BITS+1)'(r_rx - r_px)
                                   : (COORD_BITS+1)'(r_px - r_rx);
            r_ay <= (r_ry >= r_py) ? (COORD_BITS+1)'(r_ry - r_py)
                                   : (COORD_BITS+1)'(r_py - r_ry);
            r_ai <= r_ri; r_ab <= r_rb; r_at <= r_rt;
            r_d  <= (2*COORD_BITS+2)'(r_ax * r_ax) + (2*COORD_BITS+2)'(r_ay * r_ay);
            r_di <= r_ai; r_db <= r_ab; r_dt <= r_at;
            case (r_state)
                S_LOAD: begin
                    if (start) begin
                        if (r_cnt < NW'(MAX_POINTS)) begin
                            r_mx[r_cnt[AW-1:0]] <= i_point_x;
                            r_my[r_cnt[AW-1:0]] <= i_point_y;
                        end
                        if (i_last_point) begin
                            r_n <= (r_cnt < NW'(MAX_POINTS)) ? r_cnt + 1'b1 : r_cnt;
                            r_cnt <= '0;
                        end else if (r_cnt < NW'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    r_sq <= '0; r_root <= '0;
                    r_stat <= init_stat;
                    r_px <= r_mx[0]; r_py <= r_my[0];
                    r_pick <= '0; r_step <= '0;
                    r_i <= '0; r_pick_v <= 1'b0;
                    r_ph <= 1'b1;
                end
                S_SCAN: begin
                    // issue reads across all points, then drain pipeline
                    if (r_ph) begin
                        r_rv <= 1'b1;
                        r_ri <= r_i;
                        r_rx <= r_mx[r_i]; r_ry <= r_my[r_i];
                        r_rb <= (r_step == '0) ? {DIST_W{1'b1}} : r_best[r_i];
                        r_rt <= (r_step == '0) ? (r_i == '0) :
                                (r_intree[r_i] || r_i == r_pick);
                        if (NW'(r_i) + 1'b1 >= r_n) begin
                            r_ph <= 1'b0; r_i <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                    if (r_d_v) begin
                        r_best[r_di] <= nb;
                        r_intree[r_di] <= r_dt;
                        if (!r_dt && (!r_pick_v || nb < r_pick_d)) begin
                            r_pick_v <= 1'b1; r_pick_d <= nb; r_pick <= r_di;
                        end
                    end
                end
                S_PICK: begin
                    r_step <= r_step + 1'b1;
                    r_px <= r_mx[r_pick]; r_py <= r_my[r_pick];
                    r_intree[r_pick] <= 1'b1;
                    r_pick_v <= 1'b0;
                    r_ph <= 1'b1;
                end
                S_RANK: begin
                    r_sq <= SQ_W'(c_val[rank_idx]);
                end
                S_RANKW: r_sq_go <= 1'b1;
                S_SQRT: if (sqrt_done) r_root <= root;
                S_DONE: begin
                    o_strobe <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_squared_distance = (r_stat == ST_OK) ? r_sq : '0;
    assign o_distance_fixed   = (r_stat == ST_OK) ? r_root : '0;
    assign o_status           = r_stat;
endmodule

/* hw/rtl/emst_cell.sv */
// One cell of the edge ranking chain: holds a sorted edge weight
module emst_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_ins,
    input  logic [emst_pkg::DIST_W-1:0] i_key,
    input  logic                       i_prev_gt,
    input  logic [emst_pkg::DIST_W-1:0] i_prev_val,
    input  logic                       i_prev_vld,
    output logic                       o_gt,
    output logic [emst_pkg::DIST_W-1:0] o_val,
    output logic                       o_vld
);
    import emst_pkg::*;
    logic [DIST_W-1:0] r_val;
    logic              r_vld;

    // descending order: cell holds larger values towards index 0
    assign o_gt  = r_vld && (r_val >= i_key);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (i_ins && !o_gt) begin
            if (i_prev_gt) begin
                r_val <= i_key;
                r_vld <= 1'b1;
            end else begin
                r_val <= i_prev_val;
                r_vld <= i_prev_vld;
            end
        end
    end
endmodule

/* hw/rtl/emst_sqrt.sv */
// Bit-serial integer square root, one root bit per cycle
module emst_sqrt #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [emst_pkg::SQ_W-1:0]   i_sq,
    output logic                        o_done,
    output logic [emst_pkg::FIX_W-1:0]  o_root
);
    import emst_pkg::*;
    localparam int unsigned VW = SQ_W + 2*FRACTION_BITS + 1;
    localparam int unsigned RW = (VW + 1) / 2;
    localparam int unsigned STEPS = RW;
    localparam int unsigned SW = $clog2(STEPS + 1);

    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_val;
    logic [RW-1:0]   r_root;
    logic [SW-1:0]   r_step;
    logic            r_busy;
    logic [VW+1:0]   n_rem;
    logic [VW+1:0]   trial;

    always_comb begin
        n_rem = {r_rem, r_val[VW-1 -: 2]};
        trial = (VW+2)'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= VW'({i_sq, {(2*FRACTION_BITS){1'b0}}});
                r_step <= SW'(STEPS);
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (n_rem >= trial) begin
                    r_rem  <= VW'(n_rem - trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= VW'(n_rem);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = FIX_W'(r_root);
endmodule

/* hw/rtl/emst_checker.sv */
// Port-level checker for the MST k-th largest edge block
`include "euclidean_mst_kth_largest_edge_defines.svh"
module emst_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      busy,
    input logic                      o_strobe,
    input logic [1:0]                o_status,
    input logic [emst_pkg::SQ_W-1:0] o_squared_distance
);
    import emst_pkg::*;
    // the strobe comes in the first idle cycle after a data set
    `EMST_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `EMST_ASSERT_NEXT(a_strobe_one, i_clk, i_rst_n, o_strobe, !o_strobe)
    `EMST_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_strobe, o_status <= ST_COVER)
    `EMST_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_strobe && o_status != ST_OK,
        o_squared_distance == '0)
endmodule

bind euclidean_mst_kth_largest_edge emst_checker u_emst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_strobe(o_strobe), .o_status(o_status),
    .o_squared_distance(o_squared_distance)
);

/* test/euclidean_mst_kth_largest_edge_tb.sv */
// Testbench for the MST k-th largest edge block: point sets in, one edge result per set out
`timescale 1ns / 1ps
module euclidean_mst_kth_largest_edge_tb;
    import emst_pkg::*;

    localparam int unsigned NPTS      = 512;
    localparam int unsigned FRAC      = 8;
    localparam int unsigned WDOG_MAX  = 1500000;
    localparam int unsigned SETTLE    = 40;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_point;

    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [FIX_W-1:0] fix;
        logic [1:0]       status;
    } t_edge;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic               i_last_point = 1'b0;
    logic               o_strobe;
    logic [SQ_W-1:0]    o_squared_distance;
    logic [FIX_W-1:0]   o_distance_fixed;
    logic [1:0]         o_status;

    euclidean_mst_kth_largest_edge i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_last_point       (i_last_point),
        .o_strobe           (o_strobe),
        .o_squared_distance (o_squared_distance),
        .o_distance_fixed   (o_distance_fixed),
        .o_status           (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [15:0] store_x [NPTS];
    logic signed [15:0] store_y [NPTS];
    int unsigned        held = 0;
    logic [CNT_W-1:0]   k_cfg = 10'd1;

    t_point pending_points [$];
    t_edge  expected_edges [$];
    int unsigned errors = 0;
    int unsigned points_sent = 0;
    int unsigned edges_seen = 0;
    int unsigned status_hits [3] = '{0, 0, 0};
    int unsigned idle_cycles = 0;

    function automatic longint unsigned root_fixed(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned span(int unsigned a, int unsigned b);
        longint dx, dy;
        dx = longint'(store_x[a]) - longint'(store_x[b]);
        dy = longint'(store_y[a]) - longint'(store_y[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    // Prim over the held points, then pick the k-th largest tree edge
    function automatic t_edge kth_tree_edge(int unsigned n, int unsigned k);
        t_edge            r;
        bit               joined [NPTS];
        longint unsigned  link [NPTS];
        longint unsigned  weights [$];
        int unsigned      pick;
        longint unsigned  d;
        r = '0;
        if (n < 2) begin
            r.status = ST_FEW;
            return r;
        end
        if (k >= n) begin
            r.status = ST_COVER;
            return r;
        end
        for (int unsigned i = 0; i < n; i++) begin
            joined[i] = 1'b0;
            link[i] = span(0, i);
        end
        joined[0] = 1'b1;
        for (int unsigned s = 0; s + 1 < n; s++) begin
            pick = n;
            for (int unsigned i = 0; i < n; i++)
                if (!joined[i] && (pick == n || link[i] < link[pick])) pick = i;
            joined[pick] = 1'b1;
            weights.insert(weights.size(), link[pick]);
            for (int unsigned i = 0; i < n; i++) begin
                if (!joined[i]) begin
                    d = span(pick, i);
                    if (d < link[i]) link[i] = d;
                end
            end
        end
        weights.sort();
        r.sq = SQ_W'(weights[(n - 1) - k]);
        r.fix = FIX_W'(root_fixed(weights[(n - 1) - k] << (2 * FRAC)));
        r.status = ST_OK;
        return r;
    endfunction

    task automatic note_request(t_point p);
        int unsigned k;
        if (held < NPTS) begin
            store_x[held] = p.x;
            store_y[held] = p.y;
            held++;
        end
        if (p.last) begin
            k = (k_cfg == 0) ? 1 : k_cfg;
            expected_edges.insert(expected_edges.size(), kth_tree_edge(held, k));
            held = 0;
        end
    endtask

    // driver: bursts of requests with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        t_point nxt;
        logic   drive;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive = start;
            if (start && !busy) begin
                note_request('{i_point_x, i_point_y, i_last_point});
                points_sent++;
                drive = 1'b0;
            end
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_points.size() > 0) begin
                    nxt = pending_points.pop_front();
                    i_point_x <= nxt.x;
                    i_point_y <= nxt.y;
                    i_last_point <= nxt.last;
                    drive = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            start <= drive;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_edge e;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_strobe) begin
                edges_seen++;
                if (expected_edges.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    e = expected_edges.pop_front();
                    if (o_status < 3) status_hits[o_status]++;
                    if (o_squared_distance !== e.sq) begin
                        $error("squared_distance exp %0d got %0d", e.sq, o_squared_distance);
                        errors++;
                    end
                    if (o_distance_fixed !== e.fix) begin
                        $error("distance_fixed exp %0d got %0d", e.fix, o_distance_fixed);
                        errors++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired");
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic queue_point(int x, int y, bit last);
        pending_points.insert(pending_points.size(), t_point'{16'(x), 16'(y), last});
    endtask

    task automatic queue_set(int unsigned n, int unsigned spread);
        int x, y;
        for (int unsigned i = 0; i < n; i++) begin
            if (spread == 0) begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end else begin
                x = $urandom_range(0, 2 * spread) - int'(spread);
                y = $urandom_range(0, 2 * spread) - int'(spread);
            end
            queue_point(x, y, i == n - 1);
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_points.size() != 0 || expected_edges.size() != 0 || start || busy);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_k(int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[CNT_W-1:0];
        k_cfg = v[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned n, spread;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset k of 1, lone point, extreme corners, duplicates and ties
        queue_point(5, -5, 1'b1);
        queue_point(-32768, -32768, 1'b0);
        queue_point(32767, 32767, 1'b1);
        queue_point(0, 0, 1'b0);
        queue_point(0, 0, 1'b0);
        queue_point(3, 4, 1'b0);
        queue_point(-3, 4, 1'b0);
        queue_point(32767, -32768, 1'b1);
        drain();
        write_k(0);
        queue_point(1, 1, 1'b0);
        queue_point(-32768, 32767, 1'b0);
        queue_point(2, 2, 1'b1);
        drain();
        write_k(512);
        queue_point(1, 0, 1'b0);
        queue_point(0, 1, 1'b0);
        queue_point(-1, 0, 1'b0);
        queue_point(0, -1, 1'b1);
        drain();
        write_k(2);
        queue_point(7, 7, 1'b0);
        queue_point(-7, -7, 1'b1);
        queue_point(10, 0, 1'b0);
        queue_point(0, 10, 1'b0);
        queue_point(-10, 0, 1'b1);
        drain();

        // overfull store: points past the limit are dropped, last mark still counts
        write_k(3);
        queue_set(NPTS + 2, 0);
        drain();

        // random phases, mostly small sets
        while (points_sent < 1100) begin
            case ($urandom_range(0, 5))
                0: write_k(0);
                1: write_k(1);
                2: write_k($urandom_range(2, 4));
                3: write_k($urandom_range(5, 20));
                4: write_k($urandom_range(0, 1023));
                default: write_k(1);
            endcase
            repeat ($urandom_range(3, 8)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 4;
                    2: spread = 300;
                    default: spread = $urandom_range(1, 32767);
                endcase
                queue_set(n, spread);
            end
            drain();
        end

        $display("%0d points sent, %0d results: %0d ok, %0d too few, %0d covered",
                 points_sent, edges_seen, status_hits[0], status_hits[1], status_hits[2]);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
